// ===== sv/sqfk_pkg.sv =====
// ----------------------------------------------------------------------------
// sqfk_pkg
// Shared types, constants and helpers for the skeleton quaternion FK block.
// ----------------------------------------------------------------------------
package sqfk_pkg;

   localparam int MAX_JOINTS  = 256;
   localparam int QUAT_BITS   = 16;
   localparam int QFRAC       = QUAT_BITS - 2;
   localparam int IDX_BITS    = $clog2(MAX_JOINTS);
   localparam int CNT_BITS    = 9;
   localparam int ANGLE_BITS  = 16;
   // exact product sums: 2*QUAT_BITS plus three bits of growth
   localparam int ACC_BITS    = 2 * QUAT_BITS + 3;

   // polynomial coefficients, Q30
   localparam logic [31:0] C1 = 32'd1686629713;
   localparam logic [31:0] C3 = 32'd693598668;
   localparam logic [31:0] C5 = 32'd85569306;
   localparam logic [31:0] C7 = 32'd5026995;
   localparam logic [31:0] C9 = 32'd172272;

   // quaternion product selects, in issue order
   localparam logic [1:0] PROD_ZY  = 2'd0;   // qz*qy
   localparam logic [1:0] PROD_EX  = 2'd1;   // t*qx
   localparam logic [1:0] PROD_PRE = 2'd2;   // pre*e
   localparam logic [1:0] PROD_PAR = 2'd3;   // parent*loc

   typedef logic signed [QUAT_BITS-1:0] q_type;

   typedef struct packed {
      q_type x;
      q_type y;
      q_type z;
      q_type w;
   } quat_type;

   // datapath commands
   typedef struct packed {
      logic       load;      // capture a new joint
      logic [2:0] trig_sel;  // 0..5: sin x, cos x, sin y, cos y, sin z, cos z
      logic       trig_go;   // evaluate one sine step sequence
      logic [1:0] prod_sel;  // one of the PROD_* selects
      logic       prod_go;
      logic       finish;    // write table, present result
   } cmd_type;

   typedef struct packed {
      logic busy;            // datapath unit still working
      logic use_parent;      // global product needed
   } sts_type;

   function automatic q_type sat_q(input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] mx;
      logic signed [ACC_BITS-1:0] mn;
      begin
         mx = ACC_BITS'((64'sd1 <<< (QUAT_BITS - 1)) - 1);
         mn = -mx - 1;
         if (v > mx)      sat_q = q_type'(mx);
         else if (v < mn) sat_q = q_type'(mn);
         else             sat_q = q_type'(v);
      end
   endfunction

endpackage

// ===== sv/sqfk_if.sv =====
// ----------------------------------------------------------------------------
// sqfk_req_if / sqfk_rsp_if
// Valid/ready channels for joint items and result items.
// ----------------------------------------------------------------------------
interface sqfk_req_if;
   logic                             valid;
   logic                             ready;
   logic [sqfk_pkg::IDX_BITS-1:0]    parent_index;
   logic                             has_parent;
   logic signed [15:0]               pre_x;
   logic signed [15:0]               pre_y;
   logic signed [15:0]               pre_z;
   logic signed [15:0]               pre_w;
   logic signed [15:0]               angle_x;
   logic signed [15:0]               angle_y;
   logic signed [15:0]               angle_z;
   modport source (output valid, parent_index, has_parent, pre_x, pre_y, pre_z,
                   pre_w, angle_x, angle_y, angle_z, input ready);
   modport sink   (input valid, parent_index, has_parent, pre_x, pre_y, pre_z,
                   pre_w, angle_x, angle_y, angle_z, output ready);
endinterface

interface sqfk_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sqfk_pkg::IDX_BITS-1:0]    joint_index;
   logic signed [15:0]               glob_x;
   logic signed [15:0]               glob_y;
   logic signed [15:0]               glob_z;
   logic signed [15:0]               glob_w;
   logic                             frame_end;
   logic                             parent_fault;
   modport source (output valid, joint_index, glob_x, glob_y, glob_z, glob_w,
                   frame_end, parent_fault, input ready);
   modport sink   (input valid, joint_index, glob_x, glob_y, glob_z, glob_w,
                   frame_end, parent_fault, output ready);
endinterface

// ===== sv/sqfk_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqfk_ctrl
// Sequencer: loads a joint, runs six sine evaluations and up to four
// quaternion products on the datapath, then hands the result to the output.
// ----------------------------------------------------------------------------
module sqfk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              out_free,
   input  sqfk_pkg::sts_type sts,
   output sqfk_pkg::cmd_type cmd
);
   import sqfk_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TRIG  = 3'd1;
   localparam logic [2:0] ST_TWAIT = 3'd2;
   localparam logic [2:0] ST_PROD  = 3'd3;
   localparam logic [2:0] ST_PWAIT = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] tsel_ff, tsel_in;
   logic [1:0] psel_ff, psel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tsel_ff  <= '0;
         psel_ff  <= PROD_ZY;
      end else begin
         state_ff <= state_in;
         tsel_ff  <= tsel_in;
         psel_ff  <= psel_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      tsel_in  = tsel_ff;
      psel_in  = psel_ff;
      cmd      = '0;
      cmd.trig_sel = tsel_ff;
      cmd.prod_sel = psel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               tsel_in  = '0;
               psel_in  = PROD_ZY;
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            cmd.trig_go = 1'b1;
            state_in    = ST_TWAIT;
         end
         ST_TWAIT: begin
            if (!sts.busy) begin
               if (tsel_ff == 3'd5) begin
                  state_in = ST_PROD;
               end else begin
                  tsel_in  = tsel_ff + 3'd1;
                  state_in = ST_TRIG;
               end
            end
         end
         ST_PROD: begin
            cmd.prod_go = 1'b1;
            state_in    = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (!sts.busy) begin
               if (psel_ff == PROD_PAR || (psel_ff == PROD_PRE && !sts.use_parent)) begin
                  state_in = ST_DONE;
               end else begin
                  psel_in  = psel_ff + 2'd1;
                  state_in = ST_PROD;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/sqfk_dp.sv =====
// ----------------------------------------------------------------------------
// sqfk_dp
// Datapath: one shared 34x34 multiplier used for the sine polynomial and
// the quaternion products, the global table and the joint counter.
// ----------------------------------------------------------------------------
module sqfk_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  sqfk_pkg::cmd_type              cmd,
   output sqfk_pkg::sts_type              sts,
   input  logic [sqfk_pkg::CNT_BITS-1:0]  joint_count,
   input  logic [sqfk_pkg::IDX_BITS-1:0]  in_parent,
   input  logic                           in_has_parent,
   input  sqfk_pkg::quat_type             in_pre,
   input  logic [sqfk_pkg::ANGLE_BITS-1:0] in_ax,
   input  logic [sqfk_pkg::ANGLE_BITS-1:0] in_ay,
   input  logic [sqfk_pkg::ANGLE_BITS-1:0] in_az,
   output logic [sqfk_pkg::IDX_BITS-1:0]  res_index,
   output sqfk_pkg::quat_type             res_glob,
   output logic                           res_end,
   output logic                           res_fault
);
   import sqfk_pkg::*;

   // joint registers
   logic [IDX_BITS-1:0] parent_ff;
   logic                fault_ff, usep_ff;
   quat_type            pre_ff;
   logic [ANGLE_BITS-1:0] ang_ff [3];
   logic [IDX_BITS-1:0] ctr_ff;
   q_type               sc_ff [6];   // sin x, cos x, sin y, cos y, sin z, cos z
   quat_type            acc_q_ff;    // running product result
   quat_type            par_ff;      // parent global quaternion
   quat_type            table_mem [MAX_JOINTS];

   // shared multiplier
   logic signed [33:0]  ma, mb;
   logic signed [67:0]  mprod;
   assign mprod = ma * mb;

   // unit sequencer: step counter
   logic       busy_ff;
   logic [4:0] step_ff;
   logic       mode_ff;          // 0 sine, 1 product

   // sine registers
   logic [15:0] u_ff;
   logic [31:0] x2_ff;
   logic [31:0] t_ff;
   logic        neg_ff;

   // product registers
   quat_type            qa_ff, qb_ff;
   logic signed [ACC_BITS-1:0] sum_ff;
   quat_type            res_ff;

   assign sts.busy       = busy_ff;
   assign sts.use_parent = usep_ff;

   // operand selection for a new product
   quat_type qa_sel, qb_sel;
   always_comb begin
      unique case (cmd.prod_sel)
         PROD_ZY: begin
            qa_sel = '{x: '0, y: '0, z: sc_ff[4], w: sc_ff[5]};
            qb_sel = '{x: '0, y: sc_ff[2], z: '0, w: sc_ff[3]};
         end
         PROD_EX: begin
            qa_sel = acc_q_ff;
            qb_sel = '{x: sc_ff[0], y: '0, z: '0, w: sc_ff[1]};
         end
         PROD_PRE: begin
            qa_sel = pre_ff;
            qb_sel = acc_q_ff;
         end
         default: begin
            qa_sel = par_ff;
            qb_sel = acc_q_ff;
         end
      endcase
   end

   // product term k of component c: sign and operands
   logic [1:0] comp;
   logic [1:0] term;
   assign comp = step_ff[3:2];
   assign term = step_ff[1:0];

   function automatic q_type qsel(input quat_type q, input logic [1:0] i);
      unique case (i)
         2'd0:    qsel = q.x;
         2'd1:    qsel = q.y;
         2'd2:    qsel = q.z;
         default: qsel = q.w;
      endcase
   endfunction

   logic [1:0] ai, bi;
   logic       tneg;
   always_comb begin
      ai = 2'd3; bi = comp; tneg = 1'b0;
      unique case ({comp, term})
         4'h0: begin ai = 2'd3; bi = 2'd0; end
         4'h1: begin ai = 2'd0; bi = 2'd3; end
         4'h2: begin ai = 2'd1; bi = 2'd2; end
         4'h3: begin ai = 2'd2; bi = 2'd1; tneg = 1'b1; end
         4'h4: begin ai = 2'd3; bi = 2'd1; end
         4'h5: begin ai = 2'd0; bi = 2'd2; tneg = 1'b1; end
         4'h6: begin ai = 2'd1; bi = 2'd3; end
         4'h7: begin ai = 2'd2; bi = 2'd0; end
         4'h8: begin ai = 2'd3; bi = 2'd2; end
         4'h9: begin ai = 2'd0; bi = 2'd1; end
         4'hA: begin ai = 2'd1; bi = 2'd0; tneg = 1'b1; end
         4'hB: begin ai = 2'd2; bi = 2'd3; end
         4'hC: begin ai = 2'd3; bi = 2'd3; end
         4'hD: begin ai = 2'd0; bi = 2'd0; tneg = 1'b1; end
         4'hE: begin ai = 2'd1; bi = 2'd1; tneg = 1'b1; end
         default: begin ai = 2'd2; bi = 2'd2; tneg = 1'b1; end
      endcase
   end

   // sine step operands: step 0 x^2, 1..4 Horner, 5 u*t
   logic [31:0] coef;
   always_comb begin
      unique case (step_ff[2:0])
         3'd1:    coef = C7;
         3'd2:    coef = C5;
         3'd3:    coef = C3;
         default: coef = C1;
      endcase
   end

   always_comb begin
      ma = '0; mb = '0;
      if (mode_ff) begin
         ma = 34'(qsel(qa_ff, ai));
         mb = 34'(qsel(qb_ff, bi));
      end else if (step_ff == 5'd0) begin
         ma = 34'({1'b0, u_ff});
         mb = 34'({1'b0, u_ff});
      end else if (step_ff == 5'd5) begin
         ma = 34'({1'b0, u_ff});
         mb = {2'b00, t_ff};
      end else begin
         ma = {2'b00, x2_ff};
         mb = {2'b00, t_ff};
      end
   end

   // rounding of a product sum and of the sine result
   logic signed [ACC_BITS-1:0] rsum;
   logic signed [ACC_BITS-1:0] nsum;
   assign nsum = tneg ? (sum_ff - ACC_BITS'(mprod)) : (sum_ff + ACC_BITS'(mprod));
   assign rsum = (nsum + ACC_BITS'(1 <<< (QFRAC - 1))) >>> QFRAC;

   logic [50:0] rr;
   logic [QFRAC+1:0] qs;
   logic [31:0] hsh;
   logic [31:0] tn;
   assign rr  = 51'(mprod >> 15);
   // round half up from Q30 to QFRAC fraction bits
   assign qs  = (QFRAC+2)'((rr + (51'(1) << (30 - QFRAC - 1))) >> (30 - QFRAC));
   assign hsh = 32'(mprod >> 30);
   assign tn  = coef - hsh;

   logic [15:0] ang_sel;
   logic [15:0] habs;
   assign ang_sel = ang_ff[cmd.trig_sel[2:1]];
   assign habs    = ang_sel[15] ? (16'd0 - ang_sel) : ang_sel;

   logic [CNT_BITS-1:0] cnt_eff;
   assign cnt_eff = (joint_count == '0) ? CNT_BITS'(1) :
                    (joint_count > CNT_BITS'(MAX_JOINTS)) ? CNT_BITS'(MAX_JOINTS) :
                    joint_count;
   logic last;
   assign last = ({1'b0, ctr_ff} + CNT_BITS'(1)) >= cnt_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ctr_ff  <= '0;
      end else begin
         if (cmd.load) begin
            parent_ff <= in_parent;
            fault_ff  <= in_has_parent && (in_parent >= ctr_ff);
            usep_ff   <= in_has_parent && (in_parent < ctr_ff);
            pre_ff    <= in_pre;
            ang_ff[0] <= in_ax;
            ang_ff[1] <= in_ay;
            ang_ff[2] <= in_az;
         end
         if (cmd.trig_go) begin
            busy_ff <= 1'b1;
            mode_ff <= 1'b0;
            step_ff <= '0;
            // even select: sine of |h|, odd: cosine from 32768-|h|
            u_ff    <= cmd.trig_sel[0] ? (16'd32768 - habs) : habs;
            neg_ff  <= !cmd.trig_sel[0] && ang_sel[15];
            t_ff    <= C9;
         end else if (cmd.prod_go) begin
            busy_ff <= 1'b1;
            mode_ff <= 1'b1;
            step_ff <= '0;
            qa_ff   <= qa_sel;
            qb_ff   <= qb_sel;
            sum_ff  <= '0;
            if (cmd.prod_sel == PROD_PRE) par_ff <= table_mem[parent_ff];
         end else if (busy_ff) begin
            step_ff  <= step_ff + 5'd1;
            if (mode_ff) begin
               if (term == 2'd3) begin
                  sum_ff <= '0;
                  unique case (comp)
                     2'd0:    res_ff.x <= sat_q(rsum);
                     2'd1:    res_ff.y <= sat_q(rsum);
                     2'd2:    res_ff.z <= sat_q(rsum);
                     default: res_ff.w <= sat_q(rsum);
                  endcase
               end else begin
                  sum_ff <= nsum;
               end
               if (step_ff == 5'd15) begin
                  busy_ff <= 1'b0;
                  unique case (comp)
                     2'd3:    acc_q_ff <= '{x: res_ff.x, y: res_ff.y, z: res_ff.z,
                                          w: sat_q(rsum)};
                     default: acc_q_ff <= res_ff;
                  endcase
               end
            end else begin
               if (step_ff == 5'd0) begin
                  x2_ff <= 32'(mprod);
               end else if (step_ff == 5'd5) begin
                  busy_ff <= 1'b0;
                  if (qs > (QFRAC+2)'(1 << QFRAC))
                     sc_ff[cmd.trig_sel] <= neg_ff ? -q_type'(1 << QFRAC)
                                                   :  q_type'(1 << QFRAC);
                  else
                     sc_ff[cmd.trig_sel] <= neg_ff ? -q_type'(qs) : q_type'(qs);
               end else begin
                  t_ff <= tn;
               end
            end
         end
         if (cmd.finish) begin
            ctr_ff <= last ? '0 : ctr_ff + IDX_BITS'(1);
         end
      end
   end

   // table write and result capture
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         table_mem[ctr_ff] <= acc_q_ff;
         res_index <= ctr_ff;
         res_glob  <= acc_q_ff;
         res_end   <= last;
         res_fault <= fault_ff;
      end
   end

endmodule

// ===== sv/skeleton_quaternion_fk.sv =====
// ----------------------------------------------------------------------------
// skeleton_quaternion_fk
// Quaternion forward kinematics over a skeleton, one joint per item.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one joint per transfer, parents before children. rsp gives
//   one result per joint: its index, global quaternion (Q1.14), an
//   end-of-frame mark and a parent fault flag.
//   csr_wr_en/csr_wr_data write joint_count (joints per frame) while idle.
//   Each joint takes a load step, six sine evaluations, three
//   (root or bad parent) or four (valid parent) quaternion products
//   on one shared multiplier and a hand-off step, which registers the
//   result and sets rsp valid.
//   One joint is in work at a time; the next is taken once the current
//   result sits in the output register, so a stalled rsp holds one result
//   and blocks the following joint at its end.
//   Reset clears the joint counter, sets joint_count to 256 and empties the
//   output register; the global table is not cleared.
// ----------------------------------------------------------------------------
module skeleton_quaternion_fk (
   input  logic                          clock,
   input  logic                          reset,
   sqfk_req_if.sink                      req,
   sqfk_rsp_if.source                    rsp,
   input  logic                          csr_wr_en,
   input  logic [sqfk_pkg::CNT_BITS-1:0] csr_wr_data
);
   import sqfk_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [CNT_BITS-1:0] count_ff;
   logic                rvalid_ff;
   logic [IDX_BITS-1:0] r_index;
   quat_type            r_glob;
   logic                r_end, r_fault;
   quat_type            pre;

   // joint count register
   always_ff @(posedge clock) begin
      if (reset)          count_ff <= CNT_BITS'(MAX_JOINTS);
      else if (csr_wr_en) count_ff <= csr_wr_data;
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset)           rvalid_ff <= 1'b0;
      else if (cmd.finish) rvalid_ff <= 1'b1;
      else if (rsp.ready)  rvalid_ff <= 1'b0;
   end

   assign pre = '{x: req.pre_x, y: req.pre_y, z: req.pre_z, w: req.pre_w};

   sqfk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .out_free  (!rvalid_ff || rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sqfk_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .joint_count   (count_ff),
      .in_parent     (req.parent_index),
      .in_has_parent (req.has_parent),
      .in_pre        (pre),
      .in_ax         (req.angle_x),
      .in_ay         (req.angle_y),
      .in_az         (req.angle_z),
      .res_index     (r_index),
      .res_glob      (r_glob),
      .res_end       (r_end),
      .res_fault     (r_fault)
   );

   assign rsp.valid        = rvalid_ff;
   assign rsp.joint_index  = r_index;
   assign rsp.glob_x       = r_glob.x;
   assign rsp.glob_y       = r_glob.y;
   assign rsp.glob_z       = r_glob.z;
   assign rsp.glob_w       = r_glob.w;
   assign rsp.frame_end    = r_end;
   assign rsp.parent_fault = r_fault;

endmodule

// ===== tb/sv/sqfk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqfk_checker
// Watches the joint and result channels and the joint_count register, predicts
// the global quaternion of every accepted joint and compares each result
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module sqfk_checker (
   input  logic                          clock,
   input  logic                          reset,
   sqfk_req_if                           req,
   sqfk_rsp_if                           rsp,
   input  logic                          csr_wr_en,
   input  logic [sqfk_pkg::CNT_BITS-1:0] csr_wr_data,
   output int                            fail_count,
   output int                            pending
);
   import sqfk_pkg::*;

   typedef struct packed {
      logic [IDX_BITS-1:0] joint_index;
      quat_type            glob;
      logic                frame_end;
      logic                parent_fault;
   } joint_result_type;

   quat_type            glob_table [MAX_JOINTS];
   logic [IDX_BITS-1:0] joint_ctr;
   logic [CNT_BITS-1:0] frame_len;
   joint_result_type    result_fifo [$];

   // exact four-term sum, round half up, saturate
   function automatic q_type round_sum(input longint p0, p1, p2, p3);
      longint acc;
      begin
         acc = (p0 + p1 + p2 + p3 + (64'sd1 <<< (QFRAC - 1))) >>> QFRAC;
         if (acc > 32767)       round_sum = 16'sh7fff;
         else if (acc < -32768) round_sum = 16'sh8000;
         else                   round_sum = q_type'(acc);
      end
   endfunction

   // Hamilton product a*b
   function automatic quat_type hamilton(input quat_type a, input quat_type b);
      longint ax, ay, az, aw, bx, by, bz, bw;
      quat_type r;
      begin
         ax = a.x; ay = a.y; az = a.z; aw = a.w;
         bx = b.x; by = b.y; bz = b.z; bw = b.w;
         r.x = round_sum(aw * bx, ax * bw, ay * bz, -(az * by));
         r.y = round_sum(aw * by, -(ax * bz), ay * bw, az * bx);
         r.z = round_sum(aw * bz, ax * by, -(ay * bx), az * bw);
         r.w = round_sum(aw * bw, -(ax * bx), -(ay * by), -(az * bz));
         hamilton = r;
      end
   endfunction

   // sin(pi/2 * u/32768), u in 0..32768
   function automatic longint quarter_sin(input logic [63:0] u);
      logic [63:0] x2, t, r, q;
      begin
         x2 = u * u;
         t  = 64'(C9);
         t  = 64'(C7) - ((x2 * t) >> 30);
         t  = 64'(C5) - ((x2 * t) >> 30);
         t  = 64'(C3) - ((x2 * t) >> 30);
         t  = 64'(C1) - ((x2 * t) >> 30);
         r  = (u * t) >> 15;
         q  = (r + (64'd1 << (30 - QFRAC - 1))) >> (30 - QFRAC);
         if (q > (64'd1 << QFRAC)) q = 64'd1 << QFRAC;
         quarter_sin = longint'(q);
      end
   endfunction

   // half-angle sine and cosine of a binary angle
   function automatic void half_trig(input logic signed [15:0] ang,
                                     output q_type s, output q_type c);
      longint h, mag, sv;
      begin
         h   = ang;
         mag = (h < 0) ? -h : h;
         sv  = quarter_sin(64'(mag));
         s   = q_type'((h < 0) ? -sv : sv);
         c   = q_type'(quarter_sin(64'(32768 - mag)));
      end
   endfunction

   // full forward-kinematics step for one joint; updates table and counter
   function automatic joint_result_type joint_fk(
         input logic [IDX_BITS-1:0] par, input logic hp,
         input quat_type pre, input logic signed [15:0] ax, ay, az);
      quat_type qx, qy, qz, euler, loc, g;
      q_type s, c;
      int eff, idx;
      logic fault, last;
      joint_result_type res;
      begin
         eff = frame_len;
         if (eff == 0) eff = 1;
         if (eff > MAX_JOINTS) eff = MAX_JOINTS;
         idx = joint_ctr;
         fault = hp && (par >= idx);
         half_trig(ax, s, c); qx = '{x: s, y: 0, z: 0, w: c};
         half_trig(ay, s, c); qy = '{x: 0, y: s, z: 0, w: c};
         half_trig(az, s, c); qz = '{x: 0, y: 0, z: s, w: c};
         euler = hamilton(hamilton(qz, qy), qx);
         loc   = hamilton(pre, euler);
         g     = (hp && !fault) ? hamilton(glob_table[par], loc) : loc;
         glob_table[idx] = g;
         last = (idx + 1 >= eff);
         res.joint_index  = IDX_BITS'(idx);
         res.glob         = g;
         res.frame_end    = last;
         res.parent_fault = fault;
         joint_ctr = last ? '0 : IDX_BITS'(idx + 1);
         joint_fk = res;
      end
   endfunction

   // track register writes, predict on request transfers, check results
   always @(posedge clock) begin
      joint_result_type exp_r;
      quat_type pre;
      if (reset) begin
         joint_ctr  = '0;
         frame_len  = CNT_BITS'(256);
         fail_count = 0;
         result_fifo.delete();
      end else begin
         if (csr_wr_en) frame_len = csr_wr_data;
         if (req.valid && req.ready) begin
            pre = '{x: req.pre_x, y: req.pre_y, z: req.pre_z, w: req.pre_w};
            result_fifo.insert(result_fifo.size(),
                               joint_fk(req.parent_index, req.has_parent, pre,
                                        req.angle_x, req.angle_y, req.angle_z));
         end
         if (rsp.valid && rsp.ready) begin
            if (result_fifo.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               exp_r = result_fifo.pop_front();
               if (rsp.joint_index !== exp_r.joint_index) begin
                  $error("joint_index expected %0d got %0d", exp_r.joint_index,
                         rsp.joint_index);
                  fail_count++;
               end
               if (rsp.glob_x !== exp_r.glob.x) begin
                  $error("glob_x expected %0d got %0d", exp_r.glob.x, rsp.glob_x);
                  fail_count++;
               end
               if (rsp.glob_y !== exp_r.glob.y) begin
                  $error("glob_y expected %0d got %0d", exp_r.glob.y, rsp.glob_y);
                  fail_count++;
               end
               if (rsp.glob_z !== exp_r.glob.z) begin
                  $error("glob_z expected %0d got %0d", exp_r.glob.z, rsp.glob_z);
                  fail_count++;
               end
               if (rsp.glob_w !== exp_r.glob.w) begin
                  $error("glob_w expected %0d got %0d", exp_r.glob.w, rsp.glob_w);
                  fail_count++;
               end
               if (rsp.frame_end !== exp_r.frame_end) begin
                  $error("frame_end expected %0d got %0d", exp_r.frame_end,
                         rsp.frame_end);
                  fail_count++;
               end
               if (rsp.parent_fault !== exp_r.parent_fault) begin
                  $error("parent_fault expected %0d got %0d", exp_r.parent_fault,
                         rsp.parent_fault);
                  fail_count++;
               end
            end
         end
      end
      pending = result_fifo.size();
   end

endmodule

// ===== tb/sv/tb_skeleton_quaternion_fk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_skeleton_quaternion_fk
// Drives joints through the skeleton FK block over several joint_count
// settings, with random gaps on both channels, a long result stall and a full
// drain; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_skeleton_quaternion_fk;
   import sqfk_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int NUM_PHASES = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CNT_BITS-1:0] csr_wr_data = '0;
   int                  fail_count;
   int                  pending;
   int                  idle_cycles = 0;
   int                  sent = 0;
   int                  shadow_idx = 0;
   int                  shadow_len = 256;
   bit                  no_gaps = 1'b0;
   bit                  hold_rsp = 1'b0;

   int phase_len [NUM_PHASES] = '{8, 1, 2, 256, 0, 257, 511, 37};

   sqfk_req_if req ();
   sqfk_rsp_if rsp ();

   skeleton_quaternion_fk u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sqfk_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #5 clock = ~clock;

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: random gaps, one long hold on request
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = no_gaps ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: rand_angle = 16'sh8000;
         1: rand_angle = 16'sh7fff;
         2: rand_angle = 16'sd0;
         default: rand_angle = 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(0, 7))
         0: rand_comp = 16'sh8000;
         1: rand_comp = 16'sh7fff;
         2, 3: rand_comp = 16'($urandom);
         default: rand_comp = 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // offer one joint and wait for its transfer
   task automatic send_joint(input logic [7:0] par, input logic hp,
                             input logic signed [15:0] px, py, pz, pw, ax, ay, az);
      int gap;
      int eff;
      begin
         gap = no_gaps ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req.valid <= 1'b1;
         req.parent_index <= par; req.has_parent <= hp;
         req.pre_x <= px; req.pre_y <= py; req.pre_z <= pz; req.pre_w <= pw;
         req.angle_x <= ax; req.angle_y <= ay; req.angle_z <= az;
         do @(posedge clock); while (!req.ready);
         sent++;
         eff = (shadow_len == 0) ? 1 : (shadow_len > MAX_JOINTS ? MAX_JOINTS : shadow_len);
         shadow_idx = (shadow_idx + 1 >= eff) ? 0 : shadow_idx + 1;
      end
   endtask

   // well-formed joint most of the time, faults and no-parent noise otherwise
   task automatic send_random_joint();
      logic [7:0] par;
      logic hp;
      int pick;
      begin
         pick = $urandom_range(0, 9);
         if (shadow_idx == 0 || pick == 0) begin
            hp = 1'b0; par = 8'($urandom);
         end else if (pick == 1) begin
            hp = 1'b1; par = 8'($urandom_range(shadow_idx, 255));
         end else begin
            hp = 1'b1; par = 8'($urandom_range(0, shadow_idx - 1));
         end
         send_joint(par, hp, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                    rand_angle(), rand_angle(), rand_angle());
      end
   endtask

   // stop offering and wait until every expected result has come
   task automatic drain();
      begin
         req.valid <= 1'b0;
         @(posedge clock);
         while (pending != 0) @(posedge clock);
         repeat (10) @(posedge clock);
      end
   endtask

   initial begin
      int i;
      req.valid = 1'b0; req.parent_index = '0; req.has_parent = 1'b0;
      req.pre_x = '0; req.pre_y = '0; req.pre_z = '0; req.pre_w = '0;
      req.angle_x = '0; req.angle_y = '0; req.angle_z = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         // register write while idle
         csr_wr_en <= 1'b1;
         csr_wr_data <= CNT_BITS'(phase_len[ph]);
         @(posedge clock);
         csr_wr_en <= 1'b0;
         shadow_len = phase_len[ph];
         no_gaps = (ph == 3);
         if (ph == 0) begin
            // directed joints: identity, angle and prerotation extremes,
            // a chain, bad parents and an ignored parent index
            send_joint(8'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
            send_joint(8'd0, 1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                       16'sh8000, 16'sh8000, 16'sh8000);
            send_joint(8'd1, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                       16'sh7fff, 16'sh7fff, 16'sh7fff);
            send_joint(8'd3, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                       16'sd16384, -16'sd16384, 16'sd8192);
            send_joint(8'd255, 1'b1, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                       16'sd1, -16'sd1, 16'sd0);
            send_joint(8'd200, 1'b0, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0,
                       16'sd0, 16'sd32767, -16'sd32767);
            send_joint(8'd2, 1'b1, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585,
                       16'sd12345, 16'sd23456, -16'sd4321);
            send_joint(8'd6, 1'b1, 16'sd0, 16'sd16384, 16'sd0, 16'sd0,
                       -16'sd32768, 16'sd0, 16'sd32767);
            for (i = 0; i < 12; i++) send_random_joint();
         end
         for (i = 0; i < 175; i++) begin
            if (ph == 2 && i == 60) hold_rsp = 1'b1;
            if (ph == 5 && i == 80) drain();
            // shorten the count mid-frame once the counter is well advanced
            if (ph == 3 && i == 100) begin
               drain();
               csr_wr_en <= 1'b1;
               csr_wr_data <= CNT_BITS'(50);
               @(posedge clock);
               csr_wr_en <= 1'b0;
               shadow_len = 50;
            end
            send_random_joint();
         end
      end

      req.valid <= 1'b0;
      @(posedge clock);
      i = 0;
      while (pending != 0 && i < 20000) begin
         @(posedge clock);
         i++;
      end
      repeat (200) @(posedge clock);
      $display("Run covered %0d joints over %0d joint_count settings,", sent, NUM_PHASES + 1);
      $display("with random channel gaps, a long result stall and drains.");
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (pending != 0) $error("%0d results never arrived", pending);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
